/* rtl/gibcr_pkg.sv */
// ----------------------------------------------------------------------------
// gibcr_pkg
// Shared sizes, levels and dot layout of the braille cell renderer.
// ----------------------------------------------------------------------------
package gibcr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 128;
    localparam int PASSES     = 5;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);

    localparam logic [10:0] LEVEL_HIGH   = 11'd255;
    localparam logic [10:0] LEVEL_LOW    = 11'd1;
    localparam logic [13:0] BRAILLE_BASE = 14'h2800;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    function automatic logic dot_dx(input logic [2:0] k);
        unique case (k)
            3'd3, 3'd4, 3'd5, 3'd7: dot_dx = 1'b1;
            default:                dot_dx = 1'b0;
        endcase
    endfunction

    function automatic logic [1:0] dot_dy(input logic [2:0] k);
        unique case (k)
            3'd0, 3'd3: dot_dy = 2'd0;
            3'd1, 3'd4: dot_dy = 2'd1;
            3'd2, 3'd5: dot_dy = 2'd2;
            default:    dot_dy = 2'd3;
        endcase
    endfunction

endpackage

/* rtl/gray_image_braille_cell_renderer_top.sv */
// Load: one pixel word per cycle while idle. The load that completes the image starts the dither:
// PASSES passes, each an error sweep (read and write-back per pixel) and a normalization
// (read, calc, 8-step serial divider, write-back per pixel), busy meanwhile.
// Emit: nine dot reads of one port, then the cell word is registered; busy until then.
// Reset clears control state and restores register defaults; image memories stay undefined.
// ----------------------------------------------------------------------------
// gray_image_braille_cell_renderer_top
// Gray image store, error-diffusion dither with normalization, braille emit.
// ----------------------------------------------------------------------------
module gray_image_braille_cell_renderer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_cell_code,
    output logic        o_row_end,
    output logic        o_last_cell,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int AW = gibcr_pkg::AW;
    localparam int XW = gibcr_pkg::XW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DRD   = 4'd1;
    localparam logic [3:0] S_DWB   = 4'd2;
    localparam logic [3:0] S_NRD   = 4'd3;
    localparam logic [3:0] S_NCALC = 4'd4;
    localparam logic [3:0] S_NDIV  = 4'd5;
    localparam logic [3:0] S_NWB   = 4'd6;
    localparam logic [3:0] S_EDOT  = 4'd7;
    localparam logic [3:0] S_EOUT  = 4'd8;

    logic [3:0]  r_state;
    logic [7:0]  r_threshold;
    logic [8:0]  r_image_width;
    logic [7:0]  r_image_height;

    logic [AW:0]   r_load_count;
    logic [2:0]    r_pass;
    logic [AW-1:0] r_idx;
    logic [XW-1:0] r_x;
    logic [6:0]    r_y;
    logic signed [8:0]  r_left;
    logic signed [10:0] r_min;
    logic signed [10:0] r_max;
    logic [18:0] r_rem;
    logic [2:0]  r_k;
    logic [7:0]  r_q;
    logic [7:0]  r_ccol;
    logic [6:0]  r_crow;
    logic [3:0]  r_dot;
    logic [7:0]  r_bits;

    logic        r_ovalid;
    logic [13:0] r_ocode;
    logic        r_orow_end;
    logic        r_olast;

    logic signed [10:0] mem_img [0:(1 << AW)-1];
    logic signed [8:0]  mem_prev [0:(1 << XW)-1];
    logic signed [10:0] r_rd;
    logic signed [8:0]  r_prd;

    // effective geometry
    logic [8:0]  eff_w;
    logic [7:0]  eff_h;
    logic [AW:0] pix_n;
    logic [7:0]  cols;
    logic [5:0]  rows;

    always_comb begin
        if (r_image_width > 9'(gibcr_pkg::MAX_WIDTH)) begin
            eff_w = 9'(gibcr_pkg::MAX_WIDTH);
        end else begin
            eff_w = {r_image_width[8:1], 1'b0};
        end
        if (eff_w < 9'd2) begin
            eff_w = 9'd2;
        end
        if (r_image_height > 8'(gibcr_pkg::MAX_HEIGHT)) begin
            eff_h = 8'(gibcr_pkg::MAX_HEIGHT);
        end else begin
            eff_h = {r_image_height[7:2], 2'b00};
        end
        if (eff_h < 8'd4) begin
            eff_h = 8'd4;
        end
    end

    assign pix_n = (AW+1)'(17'(eff_w) * 17'(eff_h));
    assign cols  = eff_w[8:1];
    assign rows  = eff_h[7:2];

    logic in_acc;
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // dither datapath
    logic               last_col, last_row;
    logic signed [11:0] e0;
    logic [8:0]         e_mag;
    logic [16:0]        e_div3;
    logic [7:0]         e_q;
    logic signed [8:0]  e_sh;
    logic signed [11:0] nd_full;
    logic signed [10:0] nd;

    always_comb begin
        last_col = ({1'b0, r_x} == 9'(eff_w - 9'd1));
        last_row = (r_y == 7'(eff_h - 8'd1));
        if (r_rd >= $signed({3'b000, r_threshold})) begin
            e0 = 12'(gibcr_pkg::LEVEL_HIGH) - 12'(r_rd);
        end else begin
            e0 = 12'(gibcr_pkg::LEVEL_LOW) - 12'(r_rd);
        end
        e_mag  = e0[11] ? 9'(-e0) : 9'(e0);
        e_div3 = 17'(e_mag) * 17'd171;
        if (!last_col && !last_row) begin
            e_q = e_div3[16:9];
        end else if (!last_col || !last_row) begin
            e_q = e_mag[8:1];
        end else begin
            e_q = e_mag[7:0];
        end
        e_sh = e0[11] ? -$signed({1'b0, e_q}) : $signed({1'b0, e_q});
        nd_full = 12'(r_rd) + 12'(r_left) + ((r_y != 7'd0) ? 12'(r_prd) : 12'sd0);
        nd = nd_full[10:0];
    end

    // normalization datapath
    logic signed [11:0] span;
    logic signed [11:0] diff;
    logic [18:0]        prod;
    logic [18:0]        dsub;
    logic               last_pix;

    assign span     = 12'(r_max) - 12'(r_min);
    assign diff     = 12'(r_rd) - 12'(r_min);
    assign prod     = (19'(diff[10:0]) << 8) - (19'(diff[10:0]) << 1);
    assign dsub     = 19'(span[10:0]) << r_k;
    assign last_pix = ({1'b0, r_idx} == (pix_n - (AW+1)'(1)));

    // emit address
    logic [8:0]  ey, ex;
    logic [17:0] erow;
    logic [AW-1:0] eaddr;
    logic        dot_hit;

    always_comb begin
        ey    = {r_crow, 2'b00} + 9'(gibcr_pkg::dot_dy(r_dot[2:0]));
        ex    = {r_ccol, 1'b0} + 9'(gibcr_pkg::dot_dx(r_dot[2:0]));
        erow  = 18'(ey) * 18'(eff_w);
        eaddr = AW'(erow + 18'(ex));
        dot_hit = (r_rd > $signed({3'b000, r_threshold}));
    end

    // memory ports
    logic          img_we;
    logic [AW-1:0] img_wa, img_ra;
    logic signed [10:0] img_wd;
    logic          prev_we;

    always_comb begin
        img_we = 1'b0;
        img_wa = r_idx;
        img_wd = nd;
        img_ra = r_idx;
        unique case (r_state)
            S_IDLE: begin
                img_we = in_acc && (i_cmd == gibcr_pkg::CMD_LOAD) && (r_pass == 3'd0)
                         && (r_load_count < pix_n);
                img_wa = r_load_count[AW-1:0];
                img_wd = $signed({3'b000, i_pixel});
            end
            S_DWB:   img_we = 1'b1;
            S_NCALC: begin
                img_we = (span <= 12'sd0);
                img_wd = gibcr_pkg::LEVEL_LOW;
            end
            S_NWB: begin
                img_we = 1'b1;
                img_wd = $signed({3'b000, r_q}) + $signed(gibcr_pkg::LEVEL_LOW);
            end
            S_EDOT:  img_ra = eaddr;
            default: img_we = 1'b0;
        endcase
        prev_we = (r_state == S_DWB) && !last_row;
    end

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            mem_img[img_wa] <= img_wd;
        end
        r_rd <= mem_img[img_ra];
        if (prev_we) begin
            mem_prev[r_x] <= e_sh;
        end
        r_prd <= mem_prev[r_x];
    end

    logic out_free;
    logic [AW:0] n_load_count;
    assign out_free     = !r_ovalid || !i_stall;
    assign n_load_count = r_load_count + (AW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_threshold    <= 8'd128;
            r_image_width  <= 9'd256;
            r_image_height <= 8'd128;
            r_load_count   <= '0;
            r_pass         <= 3'd0;
            r_idx          <= '0;
            r_x            <= '0;
            r_y            <= 7'd0;
            r_left         <= 9'sd0;
            r_min          <= gibcr_pkg::LEVEL_HIGH;
            r_max          <= gibcr_pkg::LEVEL_LOW;
            r_ccol         <= 8'd0;
            r_crow         <= 7'd0;
            r_dot          <= 4'd0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gibcr_pkg::CFG_THRESHOLD: r_threshold    <= i_cfg_data[7:0];
                    gibcr_pkg::CFG_WIDTH:     r_image_width  <= i_cfg_data;
                    gibcr_pkg::CFG_HEIGHT:    r_image_height <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && (r_state != S_EOUT)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == gibcr_pkg::CMD_LOAD) && (r_pass == 3'd0)) begin
                        if (r_load_count < pix_n) begin
                            r_load_count <= n_load_count;
                        end
                        if (r_load_count >= pix_n || n_load_count >= pix_n) begin
                            r_idx   <= '0;
                            r_x     <= '0;
                            r_y     <= 7'd0;
                            r_left  <= 9'sd0;
                            r_min   <= gibcr_pkg::LEVEL_HIGH;
                            r_max   <= gibcr_pkg::LEVEL_LOW;
                            r_state <= S_DRD;
                        end
                    end else if (in_acc && (i_cmd == gibcr_pkg::CMD_EMIT) && (r_pass != 3'd0)) begin
                        if (r_ccol >= cols) begin
                            r_ccol <= cols - 8'd1;
                        end
                        if (r_crow >= 7'(rows)) begin
                            r_crow <= 7'(rows) - 7'd1;
                        end
                        r_dot   <= 4'd0;
                        r_bits  <= 8'd0;
                        r_state <= S_EDOT;
                    end
                end
                S_DRD: r_state <= S_DWB;
                S_DWB: begin
                    r_left <= last_col ? 9'sd0 : e_sh;
                    if (nd > r_max) begin
                        r_max <= nd;
                    end
                    if (nd < r_min) begin
                        r_min <= nd;
                    end
                    if (last_col && last_row) begin
                        r_idx   <= '0;
                        r_state <= S_NRD;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_DRD;
                        if (last_col) begin
                            r_x <= '0;
                            r_y <= r_y + 7'd1;
                        end else begin
                            r_x <= r_x + XW'(1);
                        end
                    end
                end
                S_NRD: r_state <= S_NCALC;
                S_NCALC: begin
                    if (span <= 12'sd0) begin
                        r_state <= S_NWB;
                        r_q     <= 8'd0;
                    end else begin
                        r_rem   <= prod;
                        r_k     <= 3'd7;
                        r_q     <= 8'd0;
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (r_rem >= dsub) begin
                        r_rem      <= r_rem - dsub;
                        r_q[r_k]   <= 1'b1;
                    end
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_state <= S_NWB;
                    end
                end
                S_NWB: begin
                    if (last_pix) begin
                        r_idx  <= '0;
                        r_x    <= '0;
                        r_y    <= 7'd0;
                        r_left <= 9'sd0;
                        r_min  <= gibcr_pkg::LEVEL_HIGH;
                        r_max  <= gibcr_pkg::LEVEL_LOW;
                        r_pass <= r_pass + 3'd1;
                        if (r_pass == 3'(gibcr_pkg::PASSES - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_DRD;
                        end
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_NRD;
                    end
                end
                S_EDOT: begin
                    if (r_dot != 4'd0) begin
                        r_bits[r_dot[2:0] - 3'd1] <= dot_hit;
                    end
                    if (r_dot == 4'd8) begin
                        r_state <= S_EOUT;
                    end else begin
                        r_dot <= r_dot + 4'd1;
                    end
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_ocode    <= gibcr_pkg::BRAILLE_BASE | {6'd0, r_bits};
                        r_orow_end <= (9'(r_ccol) + 9'd1 == 9'(cols));
                        r_olast    <= (9'(r_ccol) + 9'd1 == 9'(cols))
                                      && (7'(r_crow) + 7'd1 == 7'(rows));
                        r_state    <= S_IDLE;
                        if (9'(r_ccol) + 9'd1 == 9'(cols)) begin
                            r_ccol <= 8'd0;
                            if (r_crow + 7'd1 == 7'(rows)) begin
                                r_crow       <= 7'd0;
                                r_load_count <= '0;
                                r_pass       <= 3'd0;
                                r_left       <= 9'sd0;
                                r_min        <= gibcr_pkg::LEVEL_HIGH;
                                r_max        <= gibcr_pkg::LEVEL_LOW;
                            end else begin
                                r_crow <= r_crow + 7'd1;
                            end
                        end else begin
                            r_ccol <= r_ccol + 8'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_cell_code = r_ocode;
    assign o_row_end   = r_orow_end;
    assign o_last_cell = r_olast;

endmodule
